// File: sv/sha_pkg.sv
// Shared types, round constants and SHA-256 helper functions.
package sha_pkg;

    localparam int unsigned ROUNDS = 64;

    typedef logic [31:0]       word_t;
    typedef logic [7:0][31:0]  hash_t;   // [0] = a ... [7] = h
    typedef logic [15:0][31:0] win_t;    // schedule window, [0] is the oldest word

    typedef struct packed {
        logic       valid;
        logic [2:0] word_index;
        logic [4:0] bit_index;
    } ctrl_t;

    localparam word_t RC [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t iv_word(input logic [2:0] idx);
        word_t w;
        begin
            case (idx)
                3'd0:    w = 32'h6a09e667;
                3'd1:    w = 32'hbb67ae85;
                3'd2:    w = 32'h3c6ef372;
                3'd3:    w = 32'ha54ff53a;
                3'd4:    w = 32'h510e527f;
                3'd5:    w = 32'h9b05688c;
                3'd6:    w = 32'h1f83d9ab;
                default: w = 32'h5be0cd19;
            endcase
            return w;
        end
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        begin
            return (x >> n) | (x << (32 - n));
        end
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        begin
            return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
        end
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        begin
            return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
        end
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        begin
            return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
        end
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        begin
            return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
        end
    endfunction

endpackage

// File: sv/sha_stage.sv
// One registered compression round plus one message schedule step.
module sha_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  sha_pkg::word_t k_const,
    input  sha_pkg::ctrl_t ctrl_in,
    input  sha_pkg::hash_t state_in,
    input  sha_pkg::win_t  win_in,
    output sha_pkg::ctrl_t ctrl_out,
    output sha_pkg::hash_t state_out,
    output sha_pkg::win_t  win_out
);
    import sha_pkg::*;

    ctrl_t ctrl_reg;
    hash_t state_reg;
    hash_t state_next;
    win_t  win_reg;
    win_t  win_next;
    word_t t1;
    word_t t2;
    word_t choose;
    word_t major;

    always_comb
    begin
        choose = (state_in[4] & state_in[5]) ^ (~state_in[4] & state_in[6]);
        major  = (state_in[0] & state_in[1]) ^ (state_in[0] & state_in[2])
               ^ (state_in[1] & state_in[2]);
        t1 = state_in[7] + big_sigma1(state_in[4]) + choose + k_const + win_in[0];
        t2 = big_sigma0(state_in[0]) + major;

        state_next[0] = t1 + t2;
        state_next[1] = state_in[0];
        state_next[2] = state_in[1];
        state_next[3] = state_in[2];
        state_next[4] = state_in[3] + t1;
        state_next[5] = state_in[4];
        state_next[6] = state_in[5];
        state_next[7] = state_in[6];
    end

    // window slides by one; new word is w[i+16] from w[i], w[i+1], w[i+9], w[i+14]
    always_comb
    begin
        for (int j = 0; j < 15; j++)
        begin
            win_next[j] = win_in[j + 1];
        end
        win_next[15] = small_sigma1(win_in[14]) + win_in[9]
                     + small_sigma0(win_in[1]) + win_in[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        win_reg   <= win_next;
    end

    assign ctrl_out  = ctrl_reg;
    assign state_out = state_reg;
    assign win_out   = win_reg;

endmodule

// File: sv/sha_final.sv
// Final hash addition on the selected word, bit select and result register.
module sha_final (
    input  logic           clk,
    input  logic           rst_n,
    input  sha_pkg::ctrl_t ctrl_in,
    input  sha_pkg::hash_t state_in,
    output logic           done,
    output logic [31:0]    digest_word,
    output logic           digest_bit
);
    import sha_pkg::*;

    logic  done_reg;
    word_t digest_word_reg;
    word_t digest_word_next;
    logic  digest_bit_reg;
    logic  digest_bit_next;

    always_comb
    begin
        digest_word_next = state_in[ctrl_in.word_index] + iv_word(ctrl_in.word_index);
        digest_bit_next  = digest_word_next[ctrl_in.bit_index];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        digest_word_reg <= digest_word_next;
        digest_bit_reg  <= digest_bit_next;
    end

    assign done        = done_reg;
    assign digest_word = digest_word_reg;
    assign digest_bit  = digest_bit_reg;

endmodule

// File: sv/sha256_single_word_block_bit.sv
// Top level: 64-stage SHA-256 compression pipeline for single-word blocks.
//
// Usage:
//   Drive message_word, word_index and bit_index with start high; the item
//   is transferred at the rising edge where start is high and busy is low.
//   busy is always low, so a new item may be started in every cycle.
//   The block is hashed as message_word followed by fifteen zero words,
//   from the standard initial hash values, with no padding.
//   An item that is transferred shows done high, with digest_word and digest_bit,
//   once it has passed the 64 round stage registers and the output register.
//   Throughput: one item per cycle, set by one round per pipeline stage
//   (64 round stages with their schedule windows, then one output stage).
//   done is a one-cycle strobe; the result is transferred at the edge that
//   ends that cycle, and the receiver cannot hold it off.
//   Reset (rst_n low, asynchronous) clears all valid bits, so no done strobe
//   follows for items in flight; no clearing pass is needed.
module sha256_single_word_block_bit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] message_word,
    input  logic [2:0]  word_index,
    input  logic [4:0]  bit_index,
    output logic        done,
    output logic        digest_bit,
    output logic [31:0] digest_word
);
    import sha_pkg::*;

    ctrl_t ctrl_pipe  [ROUNDS + 1];
    hash_t state_pipe [ROUNDS + 1];
    win_t  win_pipe   [ROUNDS + 1];

    assign busy = 1'b0;

    assign ctrl_pipe[0]  = {start, word_index, bit_index};
    // slot [0] holds a, so H0 sits at the low end
    assign state_pipe[0] = {iv_word(3'd7), iv_word(3'd6), iv_word(3'd5), iv_word(3'd4),
                            iv_word(3'd3), iv_word(3'd2), iv_word(3'd1), iv_word(3'd0)};
    assign win_pipe[0]   = {{15{32'h0}}, message_word};

    for (genvar g = 0; g < ROUNDS; g++)
    begin : g_round
        sha_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .k_const   (RC[g]),
            .ctrl_in   (ctrl_pipe[g]),
            .state_in  (state_pipe[g]),
            .win_in    (win_pipe[g]),
            .ctrl_out  (ctrl_pipe[g + 1]),
            .state_out (state_pipe[g + 1]),
            .win_out   (win_pipe[g + 1])
        );
    end

    sha_final u_final (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl_in     (ctrl_pipe[ROUNDS]),
        .state_in    (state_pipe[ROUNDS]),
        .done        (done),
        .digest_word (digest_word),
        .digest_bit  (digest_bit)
    );

    // every transfer gives a done strobe once it has passed the round stages and the output register
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##65 done)
        else $error("transfer without result strobe");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##65 !done)
        else $error("result strobe without transfer");

    a_bit_matches_word: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ctrl_pipe[ROUNDS].valid) |->
            (digest_bit == digest_word[$past(ctrl_pipe[ROUNDS].bit_index)]))
        else $error("digest_bit does not match selected bit of digest_word");

endmodule
